/* rtl/swdi_pkg.sv */
// Shared types and constants for the stepper wave-drive indexer.
// No dependencies; used by swdi_slot and stepper_wave_drive_indexer.
package swdi_pkg;

  localparam int unsigned CoilCount  = 4;
  localparam int unsigned PhaseOutW  = 2;
  localparam int unsigned PosOutW    = 16;
  localparam int unsigned CfgW       = 16;
  localparam int unsigned InDataW    = 24;
  localparam int unsigned OutDataW   = 24;
  localparam int unsigned ApbAddrW   = 3;
  localparam int unsigned ApbDataW   = 32;

  // Register index, taken from paddr[2]
  typedef enum logic {
    REG_MAX_POSITION = 1'b0,
    REG_STEP_DELAY   = 1'b1
  } reg_idx_e;

  // Request kind carried on tuser
  typedef enum logic {
    MODE_MOVE = 1'b0,
    MODE_TICK = 1'b1
  } mode_e;

  typedef struct packed {
    logic                 busy_res;
    logic [PosOutW-1:0]   position;
    logic [PhaseOutW-1:0] phase;
    logic [CoilCount-1:0] coils;
  } result_t;

endpackage

/* rtl/stepper_wave_drive_indexer.sv */
// Top level of the four-coil wave-drive stepper indexer: APB registers,
// indexer state and the result register. Depends on swdi_pkg, swdi_slot.
//
//  channel   | dir | contents
//  s_axis    | in  | tuser = mode, tdata = step_count, direction
//  m_axis    | out | tdata = coils, phase, position, busy_res
//  apb       | in  | max_position @ 0x0, step_delay @ 0x4
//
// One request per cycle unless stalled; the result is registered on acceptance.
// State and result register update in the same cycle as acceptance.
// s_axis_tready is low only while a result waits and m_axis_tready is low.
// rst_ni clears all but res_q; max_position resets to 65535, step_delay to 1.
module stepper_wave_drive_indexer #(
  parameter int unsigned PHASE_COUNT   = 4,
  parameter int unsigned POSITION_BITS = 16
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // [15:0] step_count, [16] direction, [23:17] zero
  input  logic [swdi_pkg::InDataW-1:0]    s_axis_tdata,
  // [0] mode
  input  logic                            s_axis_tuser,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // [3:0] coils, [5:4] phase, [21:6] position, [22] busy_res, [23] zero
  output logic [swdi_pkg::OutDataW-1:0]   m_axis_tdata,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [swdi_pkg::ApbAddrW-1:0]   paddr,
  input  logic [swdi_pkg::ApbDataW-1:0]   pwdata,
  output logic [swdi_pkg::ApbDataW-1:0]   prdata,
  output logic                            pready
);

  localparam int unsigned PhW  = $clog2(PHASE_COUNT);
  localparam int unsigned CfgW = swdi_pkg::CfgW;
  localparam int unsigned ExtW = (POSITION_BITS > swdi_pkg::PosOutW) ? POSITION_BITS
                                                                     : swdi_pkg::PosOutW;

  // Configuration registers
  logic [CfgW-1:0] max_pos_q, delay_q;
  logic            cfg_wr;
  swdi_pkg::reg_idx_e cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel & penable & pwrite & pready;
  assign cfg_idx = swdi_pkg::reg_idx_e'(paddr[2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_pos_q <= '1;
      delay_q   <= CfgW'(1);
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        swdi_pkg::REG_MAX_POSITION: max_pos_q <= pwdata[CfgW-1:0];
        swdi_pkg::REG_STEP_DELAY:   delay_q   <= pwdata[CfgW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      swdi_pkg::REG_MAX_POSITION: prdata = swdi_pkg::ApbDataW'(max_pos_q);
      swdi_pkg::REG_STEP_DELAY:   prdata = swdi_pkg::ApbDataW'(delay_q);
      default:                    prdata = '0;
    endcase
  end

  // Indexer state
  logic [PhW-1:0]                 phase_q, phase_d;
  logic [POSITION_BITS-1:0]       pos_q, pos_d;
  logic [CfgW-1:0]                slots_q, slots_d;
  logic [CfgW-1:0]                wait_q, wait_d;
  logic                           right_q, right_d;
  logic [swdi_pkg::CoilCount-1:0] coil_q, coil_d;

  logic              out_valid_q;
  swdi_pkg::result_t res_q, res_d;

  logic              in_acc;
  swdi_pkg::mode_e   mode;
  logic [CfgW-1:0]   count;
  logic              dir;
  logic [CfgW:0]     wait_inc;
  logic              tick_due;
  logic              run;

  logic                           slot_move;
  logic [PhW-1:0]                 slot_phase;
  logic [POSITION_BITS-1:0]       slot_pos;
  logic [swdi_pkg::CoilCount-1:0] slot_coils;
  logic [ExtW-1:0]                pos_ext;

  assign s_axis_tready = ~out_valid_q | m_axis_tready;
  assign in_acc        = s_axis_tvalid & s_axis_tready;
  assign mode          = swdi_pkg::mode_e'(s_axis_tuser);
  assign count         = s_axis_tdata[CfgW-1:0];
  assign dir           = s_axis_tdata[CfgW];

  // A zero delay compares true at once, so it acts like one
  assign wait_inc = {1'b0, wait_q} + (CfgW+1)'(1);
  assign tick_due = (slots_q != '0) && (wait_inc >= {1'b0, delay_q});
  assign run      = (mode == swdi_pkg::MODE_MOVE) ? (count != '0) : tick_due;
  assign right_d  = (mode == swdi_pkg::MODE_MOVE) ? dir : right_q;

  swdi_slot #(
    .PHASE_COUNT  (PHASE_COUNT),
    .POSITION_BITS(POSITION_BITS)
  ) u_slot (
    .phase_i  (phase_q),
    .pos_i    (pos_q),
    .right_i  (right_d),
    .max_pos_i(max_pos_q),
    .move_o   (slot_move),
    .phase_o  (slot_phase),
    .pos_o    (slot_pos),
    .coils_o  (slot_coils)
  );

  always_comb begin
    phase_d = phase_q;
    pos_d   = pos_q;
    coil_d  = coil_q;
    if (run && slot_move) begin
      phase_d = slot_phase;
      pos_d   = slot_pos;
      coil_d  = slot_coils;
    end
    if (mode == swdi_pkg::MODE_MOVE) begin
      slots_d = count - CfgW'(run);
      wait_d  = '0;
    end else begin
      slots_d = slots_q - CfgW'(run);
      if (slots_q == '0)  wait_d = wait_q;
      else if (tick_due)  wait_d = '0;
      else                wait_d = wait_inc[CfgW-1:0];
    end
  end

  assign pos_ext = ExtW'(pos_d);

  always_comb begin
    res_d.coils    = coil_d;
    res_d.phase    = swdi_pkg::PhaseOutW'(phase_d);
    res_d.position = pos_ext[swdi_pkg::PosOutW-1:0];
    res_d.busy_res = (slots_d != '0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= '0;
      pos_q       <= '0;
      slots_q     <= '0;
      wait_q      <= '0;
      right_q     <= 1'b0;
      coil_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_acc) begin
        phase_q <= phase_d;
        pos_q   <= pos_d;
        slots_q <= slots_d;
        wait_q  <= wait_d;
        right_q <= right_d;
        coil_q  <= coil_d;
      end
      if (in_acc)              out_valid_q <= 1'b1;
      else if (m_axis_tready)  out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) res_q <= res_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = swdi_pkg::OutDataW'(res_q);

  // Checks
  a_idle_no_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (slots_q == '0) |-> (wait_q == '0))
    else $error("wait count left over while idle");

  a_coil_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(coil_q))
    else $error("more than one coil driven");

  a_phase_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (32'(phase_q) < PHASE_COUNT))
    else $error("phase out of range");

  a_idle_tick_still: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && mode == swdi_pkg::MODE_TICK && slots_q == '0) |=> $stable(pos_q))
    else $error("idle tick moved the position");

  a_one_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> (pos_q == $past(pos_q) || pos_q == $past(pos_q) + POSITION_BITS'(1) ||
                pos_q == $past(pos_q) - POSITION_BITS'(1)))
    else $error("position moved more than one step");

endmodule

/* rtl/swdi_slot.sv */
// One step slot: limit test, phase wrap, position step and coil decode.
// Uses swdi_pkg for the coil count and configuration width.
module swdi_slot #(
  parameter int unsigned PHASE_COUNT   = 4,
  parameter int unsigned POSITION_BITS = 16,
  localparam int unsigned PhW          = $clog2(PHASE_COUNT)
) (
  input  logic [PhW-1:0]                   phase_i,
  input  logic [POSITION_BITS-1:0]         pos_i,
  input  logic                             right_i,
  input  logic [swdi_pkg::CfgW-1:0]        max_pos_i,
  output logic                             move_o,
  output logic [PhW-1:0]                   phase_o,
  output logic [POSITION_BITS-1:0]         pos_o,
  output logic [swdi_pkg::CoilCount-1:0]   coils_o
);

  localparam int unsigned CmpW = (POSITION_BITS > swdi_pkg::CfgW) ? POSITION_BITS
                                                                  : swdi_pkg::CfgW;
  localparam logic [PhW-1:0] PhLast = PhW'(PHASE_COUNT - 1);

  logic [CmpW-1:0] pos_ext, max_ext;

  assign pos_ext = CmpW'(pos_i);
  assign max_ext = CmpW'(max_pos_i);

  // Right is also blocked at the top of the counter
  assign move_o = right_i ? ((pos_ext < max_ext) && (pos_i != '1))
                          : (pos_i != '0);

  always_comb begin
    coils_o = '0;
    for (int unsigned i = 0; i < swdi_pkg::CoilCount; i++) begin
      if (32'(phase_i) == i) coils_o[i] = 1'b1;
    end
  end

  always_comb begin
    if (right_i) begin
      phase_o = (phase_i == PhLast) ? '0 : phase_i + PhW'(1);
      pos_o   = pos_i + POSITION_BITS'(1);
    end else begin
      phase_o = (phase_i == '0) ? PhLast : phase_i - PhW'(1);
      pos_o   = pos_i - POSITION_BITS'(1);
    end
  end

endmodule

/* tb/tb_top.sv */
// Self-checking testbench for stepper_wave_drive_indexer: streams move and tick
// requests, predicts coils/phase/position/busy per request and checks each result.
// Depends on swdi_pkg and the stepper_wave_drive_indexer RTL.
module tb_top;

  localparam int unsigned PHASES         = 4;
  localparam int unsigned RANDOM_ITEMS   = 1000;
  localparam int unsigned STEADY_ITEMS   = 200;
  localparam int unsigned WATCHDOG_LIMIT = 2000;
  localparam int unsigned LONG_HOLD      = 300;
  localparam int unsigned SETTLE_CYCLES  = 4;
  localparam int unsigned MAX_TICK_RUN   = 80;

  logic                          clk_i = 1'b0;
  logic                          rst_ni;
  logic                          s_axis_tvalid;
  logic                          s_axis_tready;
  // [15:0] step_count, [16] direction, [23:17] zero
  logic [swdi_pkg::InDataW-1:0]  s_axis_tdata;
  // [0] mode
  logic                          s_axis_tuser;
  logic                          m_axis_tvalid;
  logic                          m_axis_tready;
  // [3:0] coils, [5:4] phase, [21:6] position, [22] busy_res, [23] zero
  logic [swdi_pkg::OutDataW-1:0] m_axis_tdata;
  logic                          psel;
  logic                          penable;
  logic                          pwrite;
  logic [swdi_pkg::ApbAddrW-1:0] paddr;
  logic [swdi_pkg::ApbDataW-1:0] pwdata;
  logic [swdi_pkg::ApbDataW-1:0] prdata;
  logic                          pready;

  stepper_wave_drive_indexer dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Indexer shadow state and register copies
  logic [1:0]  phase_q;
  logic [15:0] position_q;
  logic [15:0] slots_q;
  logic [15:0] waited_q;
  logic        right_q;
  logic [3:0]  coils_q;
  logic [15:0] max_position_cfg;
  logic [15:0] step_delay_cfg;

  swdi_pkg::result_t expected_moves[$];
  int unsigned error_count;
  int unsigned moves_sent;
  bit          sender_gaps;
  bit          receiver_stalls;
  int unsigned hold_request;

  function automatic void run_step_slot();
    logic can_move;
    can_move = right_q ? (position_q < max_position_cfg && position_q != 16'hFFFF)
                       : (position_q != 16'd0);
    if (!can_move) return;
    coils_q = 4'b0001 << phase_q;
    if (right_q) begin
      phase_q    = (phase_q == PHASES - 1) ? 2'd0 : phase_q + 2'd1;
      position_q = position_q + 16'd1;
    end else begin
      phase_q    = (phase_q == 2'd0) ? 2'(PHASES - 1) : phase_q - 2'd1;
      position_q = position_q - 16'd1;
    end
  endfunction

  function automatic swdi_pkg::result_t advance_indexer(input swdi_pkg::mode_e mode,
                                                        input logic [15:0] count,
                                                        input logic dir);
    logic [16:0]       waited_next;
    swdi_pkg::result_t res;
    if (mode == swdi_pkg::MODE_MOVE) begin
      right_q  = dir;
      waited_q = 16'd0;
      slots_q  = count;
      if (slots_q != 16'd0) begin
        run_step_slot();
        slots_q = slots_q - 16'd1;
      end
    end else if (slots_q != 16'd0) begin
      waited_next = {1'b0, waited_q} + 17'd1;
      // a delay of zero behaves like one
      if (waited_next >= {1'b0, step_delay_cfg}) begin
        waited_q = 16'd0;
        run_step_slot();
        slots_q = slots_q - 16'd1;
      end else begin
        waited_q = waited_next[15:0];
      end
    end
    res.coils    = coils_q;
    res.phase    = phase_q;
    res.position = position_q;
    res.busy_res = (slots_q != 16'd0);
    return res;
  endfunction

  function automatic void report_mismatch(input string field, input int unsigned want,
                                          input int unsigned got);
    $display("%0t: %s mismatch, expected %0d actual %0d", $time, field, want, got);
    error_count++;
  endfunction

  // Sender: one request, left valid afterwards so back-to-back requests stay high
  task automatic send_request(input swdi_pkg::mode_e mode, input logic [15:0] count,
                              input logic dir);
    if (sender_gaps && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= mode;
    s_axis_tdata  <= {7'd0, dir, count};
    @(negedge clk_i);
    while (!s_axis_tready) @(negedge clk_i);
    @(posedge clk_i);
    expected_moves.push_back(advance_indexer(mode, count, dir));
    moves_sent++;
  endtask

  task automatic send_tick();
    send_request(swdi_pkg::MODE_TICK, 16'($urandom_range(0, 65535)),
                 1'($urandom_range(0, 1)));
  endtask

  // Command followed by the ticks it needs plus spare ones, capped at MAX_TICK_RUN
  task automatic run_move(input logic [15:0] count, input logic dir, input int extra);
    longint ticks;
    send_request(swdi_pkg::MODE_MOVE, count, dir);
    ticks = (count > 1) ? longint'(count - 1) * step_delay_cfg + extra : extra;
    if (ticks > MAX_TICK_RUN) ticks = MAX_TICK_RUN;
    repeat (int'(ticks)) send_tick();
  endtask

  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    while (expected_moves.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_register(input swdi_pkg::reg_idx_e idx, input logic [15:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= {16'd0, value};
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    if (idx == swdi_pkg::REG_MAX_POSITION) max_position_cfg = value;
    else step_delay_cfg = value;
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
    // read back
    psel    <= 1'b1;
    pwrite  <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    @(negedge clk_i);
    if (prdata !== {16'd0, value}) begin
      $display("%0t: register %s readback mismatch, expected %0d actual %0d",
               $time, idx.name(), value, prdata);
      error_count++;
    end
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic set_registers(input logic [15:0] max_position, input logic [15:0] delay);
    drain_results();
    write_register(swdi_pkg::REG_MAX_POSITION, max_position);
    write_register(swdi_pkg::REG_STEP_DELAY, delay);
  endtask

  task automatic test_limits_and_wrap();
    send_tick();                        // idle tick does nothing
    send_request(swdi_pkg::MODE_MOVE, 16'd3, 1'b0);  // left at position zero: blocked
    send_tick();
    send_tick();
    send_request(swdi_pkg::MODE_MOVE, 16'd0, 1'b1);
    run_move(16'd6, 1'b1, 0);           // phase wraps 3 -> 0
    send_request(swdi_pkg::MODE_MOVE, 16'd2, 1'b0);  // left move once the right move is done
    send_tick();
    send_tick();
    send_request(swdi_pkg::MODE_MOVE, 16'hFFFF, 1'b1);
    send_tick();
    send_tick();
    send_request(swdi_pkg::MODE_MOVE, 16'd0, 1'b0);  // zero count stops the long move
    // lower the limit below the current position
    set_registers(16'd3, 16'd1);
    run_move(16'd2, 1'b1, 0);
    run_move(16'd3, 1'b0, 0);
    run_move(16'd4, 1'b1, 1);
  endtask

  task automatic test_register_extremes();
    set_registers(16'd0, 16'd1);
    run_move(16'd4, 1'b1, 0);
    run_move(16'd8, 1'b0, 1);
    set_registers(16'hFFFF, 16'hFFFF);
    run_move(16'd5, 1'b1, 10);
    run_move(16'd2, 1'b0, 3);
    set_registers(16'd1, 16'd2);
    run_move(16'd6, 1'b1, 0);
    run_move(16'd6, 1'b0, 0);
    set_registers(16'd7, 16'd3);
    run_move(16'd12, 1'b1, 2);
  endtask

  task automatic random_phase(input int unsigned item_count);
    int unsigned  phase_start;
    logic [15:0]  count;
    phase_start = moves_sent;
    while (moves_sent < phase_start + item_count) begin
      case ($urandom_range(0, 9))
        0: send_request(swdi_pkg::mode_e'($urandom_range(0, 1)),
                        16'($urandom_range(0, 65535)), 1'($urandom_range(0, 1)));
        1: begin
          // command that the next one may cut short
          send_request(swdi_pkg::MODE_MOVE, 16'($urandom_range(2, 20)),
                       1'($urandom_range(0, 1)));
          repeat ($urandom_range(0, 3)) send_tick();
        end
        default: begin
          count = ($urandom_range(0, 9) == 0) ? 16'($urandom_range(0, 65535))
                                              : 16'($urandom_range(1, 12));
          run_move(count, 1'($urandom_range(0, 1)), $urandom_range(0, 3));
        end
      endcase
    end
  endtask

  task automatic test_random_moves();
    int unsigned start;
    logic [15:0] max_position;
    logic [15:0] delay;
    start = moves_sent;
    while (moves_sent < start + RANDOM_ITEMS) begin
      case ($urandom_range(0, 5))
        0: max_position = 16'd0;
        1: max_position = 16'hFFFF;
        2: max_position = position_q;
        default: max_position = 16'($urandom_range(0, 40));
      endcase
      case ($urandom_range(0, 9))
        0: delay = 16'hFFFF;
        1: delay = 16'($urandom_range(1, 65535));
        default: delay = 16'($urandom_range(1, 4));
      endcase
      set_registers(max_position, delay);
      random_phase(150);
    end
  endtask

  task automatic test_output_backpressure();
    set_registers(16'd30, 16'd1);
    sender_gaps  = 1'b0;
    hold_request = LONG_HOLD;
    random_phase(40);
    sender_gaps  = 1'b1;
  endtask

  task automatic test_steady_stream();
    set_registers(16'd25, 16'd2);
    sender_gaps     = 1'b0;
    receiver_stalls = 1'b0;
    random_phase(STEADY_ITEMS);
  endtask

  // Receiver: random stalls, plus one long hold when requested
  initial begin
    int unsigned held;
    m_axis_tready = 1'b0;
    @(posedge clk_i);
    while (!rst_ni) @(posedge clk_i);
    forever begin
      if (hold_request != 0) begin
        m_axis_tready <= 1'b0;
        held = 0;
        while (held < hold_request) begin
          @(posedge clk_i);
          held++;
        end
        hold_request = 0;
      end else if (receiver_stalls && $urandom_range(0, 3) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 19)) @(posedge clk_i);
      end else begin
        m_axis_tready <= 1'b1;
        @(posedge clk_i);
      end
    end
  end

  // Result checker: both handshake signals are stable at the falling edge
  initial begin
    swdi_pkg::result_t got;
    swdi_pkg::result_t want;
    forever begin
      @(negedge clk_i);
      if (rst_ni && m_axis_tvalid && m_axis_tready) begin
        got = swdi_pkg::result_t'(m_axis_tdata[$bits(swdi_pkg::result_t)-1:0]);
        if (expected_moves.size() == 0) begin
          $display("%0t: result with no request pending, actual %h", $time, m_axis_tdata);
          error_count++;
        end else begin
          want = expected_moves.pop_front();
          if (got.coils !== want.coils)
            report_mismatch("coils", 32'(want.coils), 32'(got.coils));
          if (got.phase !== want.phase)
            report_mismatch("phase", 32'(want.phase), 32'(got.phase));
          if (got.position !== want.position)
            report_mismatch("position", 32'(want.position), 32'(got.position));
          if (got.busy_res !== want.busy_res)
            report_mismatch("busy_res", 32'(want.busy_res), 32'(got.busy_res));
        end
      end
    end
  end

  // Watchdog: any stream or register access counts as progress
  initial begin
    int unsigned quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(negedge clk_i);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
          (psel && penable))
        quiet = 0;
      else
        quiet++;
    end
    $display("Test completed with failures");
    $finish;
  end

  initial begin
    rst_ni           = 1'b0;
    s_axis_tvalid    = 1'b0;
    s_axis_tdata     = '0;
    s_axis_tuser     = swdi_pkg::MODE_MOVE;
    psel             = 1'b0;
    penable          = 1'b0;
    pwrite           = 1'b0;
    paddr            = '0;
    pwdata           = '0;
    phase_q          = 2'd0;
    position_q       = 16'd0;
    slots_q          = 16'd0;
    waited_q         = 16'd0;
    right_q          = 1'b0;
    coils_q          = 4'd0;
    max_position_cfg = 16'hFFFF;
    step_delay_cfg   = 16'd1;
    error_count      = 0;
    moves_sent       = 0;
    sender_gaps      = 1'b1;
    receiver_stalls  = 1'b1;
    hold_request     = 0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_limits_and_wrap();
    test_register_extremes();
    test_random_moves();
    test_output_backpressure();
    test_steady_stream();

    drain_results();
    if (error_count == 0 && expected_moves.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

/* stepper_wave_drive_indexer.f */
rtl/swdi_pkg.sv
rtl/swdi_slot.sv
rtl/stepper_wave_drive_indexer.sv
tb/tb_top.sv
